/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the voice allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/valloc_pkg.sv */
// Package of the voice allocator: widths, event and command codes, shared types.
`timescale 1ns / 1ps
`default_nettype none

package valloc_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int MASK_W  = 8;
  localparam int ACT_W   = 2;
  localparam int VOICE_W = 3;
  localparam int STAMP_W = 32;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((NOTE_W + VEL_W + MASK_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VOICE_W + NOTE_W + VEL_W + 7) / 8) * 8;

  // Default sizes
  localparam int NUM_VOICES_DEF  = 8;
  localparam int STACK_DEPTH_DEF = 16;

  // Event kinds
  localparam logic [OP_W-1:0] OP_ON  = 2'd0;
  localparam logic [OP_W-1:0] OP_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_ALL = 2'd2;

  // Voice command codes
  localparam logic [ACT_W-1:0] ACT_START    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GLIDE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_STOP_ALL = 2'd3;

  // Result the datapath loads into its output register
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ALL,
    EMIT_POLY,
    EMIT_STOP_V,
    EMIT_MONO_ON,
    EMIT_MONO_OFF
  } emit_e;

  // Controller to datapath commands
  typedef struct packed {
    logic  load_in;
    logic  scan_clr;
    logic  drop_set;
    logic  scan_inc;
    logic  steal_step;
    logic  rm_rd;
    logic  rm_wr;
    logic  rm_done;
    logic  top_rd;
    emit_e emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            free_found;
    logic            voice_last;
    logic            off_match;
    logic            stack_end;
    logic            stack_full;
    logic            stack_empty;
    logic            out_busy;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/valloc_dpath.sv */
// Datapath of the voice allocator: voice table, stamps, held-note stack, result register.
`timescale 1ns / 1ps
`default_nettype none

module valloc_dpath #(
  parameter int NUM_VOICES  = valloc_pkg::NUM_VOICES_DEF,
  parameter int STACK_DEPTH = valloc_pkg::STACK_DEPTH_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  valloc_pkg::cmd_t                  cmd_i,
  output valloc_pkg::stat_t                 stat_o,
  input  wire [valloc_pkg::OP_W-1:0]        op_i,
  input  wire [valloc_pkg::NOTE_W-1:0]      note_i,
  input  wire [valloc_pkg::VEL_W-1:0]       vel_i,
  input  wire [valloc_pkg::MASK_W-1:0]      mask_i,
  input  wire                               m_tready_i,
  output logic                              out_valid_o,
  output logic [valloc_pkg::ACT_W-1:0]      out_action_o,
  output logic [valloc_pkg::VOICE_W-1:0]    out_voice_o,
  output logic [valloc_pkg::NOTE_W-1:0]     out_note_o,
  output logic [valloc_pkg::VEL_W-1:0]      out_vel_o
);

  localparam int VW = $clog2(NUM_VOICES);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = (CW > VW) ? CW : VW;
  localparam int MV = (NUM_VOICES < valloc_pkg::MASK_W) ? NUM_VOICES : valloc_pkg::MASK_W;

  // Latched event
  logic [valloc_pkg::OP_W-1:0]   op_q;
  logic [valloc_pkg::NOTE_W-1:0] note_q;
  logic [valloc_pkg::VEL_W-1:0]  vel_q;
  logic [valloc_pkg::MASK_W-1:0] mask_q;
  logic                          was_empty_q;

  // Voice state
  logic [valloc_pkg::NOTE_W-1:0]  voice_note_q [NUM_VOICES];
  logic [NUM_VOICES-1:0]          voice_valid_q;
  logic [valloc_pkg::STAMP_W-1:0] stamp_q [NUM_VOICES];
  logic [valloc_pkg::STAMP_W-1:0] stamp_cnt_q;
  logic [valloc_pkg::STAMP_W-1:0] stamp_next;

  // Scan state
  logic [SW-1:0]                  idx_q;
  logic [VW-1:0]                  vidx;
  logic [VW-1:0]                  best_idx_q;
  logic [valloc_pkg::STAMP_W-1:0] best_stamp_q;
  logic [CW-1:0]                  wptr_q;
  logic                           drop_q;

  // Held-note stack
  logic [valloc_pkg::NOTE_W-1:0] mem [STACK_DEPTH];
  logic [valloc_pkg::NOTE_W-1:0] rd_data_q;
  logic [CW-1:0]                 held_cnt_q;
  logic [valloc_pkg::VEL_W-1:0]  mono_vel_q;

  logic [NUM_VOICES-1:0]         sound_vec;
  logic                          free_found;
  logic [VW-1:0]                 free_idx;
  logic [VW-1:0]                 target;
  logic                          keep;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [valloc_pkg::NOTE_W-1:0] mem_wdata;
  logic [AW-1:0]                 mem_raddr;

  assign vidx       = idx_q[VW-1:0];
  assign stamp_next = stamp_cnt_q + 1'b1;
  assign target     = free_found ? free_idx : best_idx_q;

  // Sounding voices and lowest free voice; voices past the mask never sound
  always_comb begin
    sound_vec  = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < MV; i++) begin
      sound_vec[i] = mask_q[i];
    end
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!sound_vec[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  // Compaction keeps an entry unless it matches the note; a drop pass keeps all but the oldest
  assign keep = drop_q ? (idx_q != '0) : (rd_data_q != note_q);

  // Stack write and read port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr_q[AW-1:0];
    mem_wdata = rd_data_q;
    if (cmd_i.emit == valloc_pkg::EMIT_MONO_ON) begin
      mem_we    = 1'b1;
      mem_waddr = held_cnt_q[AW-1:0];
      mem_wdata = note_q;
    end else if (cmd_i.rm_wr && keep) begin
      mem_we = 1'b1;
    end
    mem_raddr = cmd_i.top_rd ? AW'(held_cnt_q - 1'b1) : idx_q[AW-1:0];
  end

  // Status
  always_comb begin
    stat_o.op          = op_q;
    stat_o.free_found  = free_found;
    stat_o.voice_last  = (idx_q == SW'(NUM_VOICES - 1));
    stat_o.off_match   = voice_valid_q[vidx] && (voice_note_q[vidx] == note_q) &&
                         sound_vec[vidx];
    stat_o.stack_end   = (idx_q >= SW'(held_cnt_q));
    stat_o.stack_full  = (held_cnt_q == CW'(STACK_DEPTH));
    stat_o.stack_empty = (held_cnt_q == '0);
    stat_o.out_busy    = out_valid_o && !m_tready_i;
  end

  // Stack memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rm_rd || cmd_i.top_rd) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // Event latch and voice notes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q        <= (op_i == valloc_pkg::OP_ON && vel_i == '0) ? valloc_pkg::OP_OFF : op_i;
      note_q      <= note_i;
      vel_q       <= vel_i;
      mask_q      <= mask_i;
      was_empty_q <= (held_cnt_q == '0);
    end
    if (cmd_i.emit == valloc_pkg::EMIT_POLY) begin
      voice_note_q[target] <= note_q;
    end
  end

  // Control state: valid bits, stamps, counters, scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_valid_q <= '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        stamp_q[i] <= '0;
      end
      stamp_cnt_q  <= '0;
      held_cnt_q   <= '0;
      mono_vel_q   <= '0;
      idx_q        <= '0;
      wptr_q       <= '0;
      drop_q       <= 1'b0;
      best_idx_q   <= '0;
      best_stamp_q <= '0;
    end else begin
      // scan counter
      if (cmd_i.scan_clr) begin
        idx_q  <= '0;
        wptr_q <= '0;
        drop_q <= cmd_i.drop_set;
      end else if (cmd_i.scan_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      // oldest stamp search, ties keep the lower voice
      if (cmd_i.steal_step && (idx_q == '0 || stamp_q[vidx] < best_stamp_q)) begin
        best_idx_q   <= vidx;
        best_stamp_q <= stamp_q[vidx];
      end
      // compaction write pointer and new count
      if (cmd_i.rm_wr && keep) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (cmd_i.rm_done) begin
        held_cnt_q <= wptr_q;
      end
      // side effects of the committed result
      case (cmd_i.emit)
        valloc_pkg::EMIT_ALL: begin
          voice_valid_q <= '0;
          held_cnt_q    <= '0;
        end
        valloc_pkg::EMIT_POLY: begin
          voice_valid_q[target] <= 1'b1;
          stamp_cnt_q           <= stamp_next;
          stamp_q[target]       <= stamp_next;
          if (target == '0) begin
            mono_vel_q <= vel_q;
          end
        end
        valloc_pkg::EMIT_STOP_V: begin
          voice_valid_q[vidx] <= 1'b0;
        end
        valloc_pkg::EMIT_MONO_ON: begin
          held_cnt_q <= held_cnt_q + 1'b1;
          mono_vel_q <= vel_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit != valloc_pkg::EMIT_NONE) begin
      out_valid_o <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.emit)
      valloc_pkg::EMIT_ALL: begin
        out_action_o <= valloc_pkg::ACT_STOP_ALL;
        out_voice_o  <= '0;
        out_note_o   <= '0;
        out_vel_o    <= '0;
      end
      valloc_pkg::EMIT_POLY: begin
        out_action_o <= valloc_pkg::ACT_START;
        out_voice_o  <= valloc_pkg::VOICE_W'(target);
        out_note_o   <= note_q;
        out_vel_o    <= vel_q;
      end
      valloc_pkg::EMIT_STOP_V: begin
        out_action_o <= valloc_pkg::ACT_STOP;
        out_voice_o  <= valloc_pkg::VOICE_W'(vidx);
        out_note_o   <= '0;
        out_vel_o    <= '0;
      end
      valloc_pkg::EMIT_MONO_ON: begin
        out_action_o <= was_empty_q ? valloc_pkg::ACT_START : valloc_pkg::ACT_GLIDE;
        out_voice_o  <= '0;
        out_note_o   <= note_q;
        out_vel_o    <= vel_q;
      end
      valloc_pkg::EMIT_MONO_OFF: begin
        out_voice_o <= '0;
        if (held_cnt_q == '0) begin
          out_action_o <= valloc_pkg::ACT_STOP;
          out_note_o   <= '0;
          out_vel_o    <= '0;
        end else begin
          out_action_o <= valloc_pkg::ACT_GLIDE;
          out_note_o   <= rd_data_q;
          out_vel_o    <= mono_vel_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/valloc_ctrl.sv */
// Controller of the voice allocator: event sequencing and the mode register.
`timescale 1ns / 1ps
`default_nettype none

module valloc_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_valid_i,
  input  wire               cfg_data_i,
  output logic              cfg_ready_o,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  valloc_pkg::stat_t stat_i,
  output valloc_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_STEAL,
    ST_ASSIGN,
    ST_OFF_SCAN,
    ST_OFF_EMIT,
    ST_RM_RD,
    ST_RM_WR,
    ST_RM_END,
    ST_ON_EMIT,
    ST_MOFF_EMIT,
    ST_ALL_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   mono_q;
  logic   ready_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ready_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.op)
          valloc_pkg::OP_ALL: state_d = ST_ALL_EMIT;
          valloc_pkg::OP_ON: begin
            if (mono_q) begin
              cmd_o.scan_clr = 1'b1;
              state_d        = ST_RM_RD;
            end else if (stat_i.free_found) begin
              state_d = ST_ASSIGN;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d        = ST_STEAL;
            end
          end
          valloc_pkg::OP_OFF: begin
            cmd_o.scan_clr = 1'b1;
            state_d        = mono_q ? ST_RM_RD : ST_OFF_SCAN;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      // one stamp compare per cycle
      ST_STEAL: begin
        cmd_o.steal_step = 1'b1;
        if (stat_i.voice_last) begin
          state_d = ST_ASSIGN;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_ASSIGN: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = valloc_pkg::EMIT_POLY;
          state_d    = ST_IDLE;
        end
      end
      // first sounding voice holding the note
      ST_OFF_SCAN: begin
        if (stat_i.off_match) begin
          state_d = ST_OFF_EMIT;
        end else if (stat_i.voice_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_OFF_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = valloc_pkg::EMIT_STOP_V;
          state_d    = ST_IDLE;
        end
      end
      // stack compaction: read an entry, then write it back if kept
      ST_RM_RD: begin
        if (stat_i.stack_end) begin
          cmd_o.rm_done = 1'b1;
          state_d       = ST_RM_END;
        end else begin
          cmd_o.rm_rd = 1'b1;
          state_d     = ST_RM_WR;
        end
      end
      ST_RM_WR: begin
        cmd_o.rm_wr    = 1'b1;
        cmd_o.scan_inc = 1'b1;
        state_d        = ST_RM_RD;
      end
      ST_RM_END: begin
        if (stat_i.op == valloc_pkg::OP_ON) begin
          if (stat_i.stack_full) begin
            // full stack: second pass drops the oldest entry
            cmd_o.scan_clr = 1'b1;
            cmd_o.drop_set = 1'b1;
            state_d        = ST_RM_RD;
          end else begin
            state_d = ST_ON_EMIT;
          end
        end else begin
          cmd_o.top_rd = !stat_i.stack_empty;
          state_d      = ST_MOFF_EMIT;
        end
      end
      ST_ON_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = valloc_pkg::EMIT_MONO_ON;
          state_d    = ST_IDLE;
        end
      end
      ST_MOFF_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = valloc_pkg::EMIT_MONO_OFF;
          state_d    = ST_IDLE;
        end
      end
      ST_ALL_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = valloc_pkg::EMIT_ALL;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, registered ready and mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b0;
      mono_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
      if (cfg_valid_i) begin
        mono_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/synth_voice_allocator_unit.sv */
// Top level of the voice allocator: stream ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Voice allocator. Takes note-on, note-off and all-notes-off requests with the
// mask of sounding voices and gives at most one voice command per request.
// One request is worked at a time; the next is taken while a result still waits
// in the output register. A poly steal scans the voice table with one stamp
// compare per cycle for the oldest voice, and a poly note-off scans it for the
// note. Mono requests compact the held-note stack memory, reading each entry
// and writing it back if kept; a mono note-on that finds the stack full makes a
// second pass that drops the oldest note. Requests that give no result go back
// to idle without passing an emit state.

module synth_voice_allocator_unit #(
  parameter int NUM_VOICES  = valloc_pkg::NUM_VOICES_DEF,
  parameter int STACK_DEPTH = valloc_pkg::STACK_DEPTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // mode register write
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire                                 cfg_data_i,    // mono_mode
  // event requests
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [valloc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // note, velocity, active_mask
  input  wire [valloc_pkg::OP_W-1:0]          s_axis_tuser,  // op
  // voice commands
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [valloc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // voice, out_note, out_velocity
  output logic [valloc_pkg::ACT_W-1:0]        m_axis_tuser   // action
);

  localparam int VEL_LO  = valloc_pkg::NOTE_W;
  localparam int MASK_LO = valloc_pkg::NOTE_W + valloc_pkg::VEL_W;

  valloc_pkg::cmd_t  cmd;
  valloc_pkg::stat_t stat;

  logic [valloc_pkg::VOICE_W-1:0] out_voice;
  logic [valloc_pkg::NOTE_W-1:0]  out_note;
  logic [valloc_pkg::VEL_W-1:0]   out_vel;

  valloc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  valloc_dpath #(
    .NUM_VOICES  (NUM_VOICES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (s_axis_tuser),
    .note_i       (s_axis_tdata[valloc_pkg::NOTE_W-1:0]),
    .vel_i        (s_axis_tdata[VEL_LO +: valloc_pkg::VEL_W]),
    .mask_i       (s_axis_tdata[MASK_LO +: valloc_pkg::MASK_W]),
    .m_tready_i   (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_action_o (m_axis_tuser),
    .out_voice_o  (out_voice),
    .out_note_o   (out_note),
    .out_vel_o    (out_vel)
  );

  // Pack the result, voice in the low bits, zero padded
  assign m_axis_tdata = valloc_pkg::OUT_DATA_W'({out_vel, out_note, out_voice});

endmodule

`default_nettype wire

/* rtl/valloc_checker.sv */
// Port-level checks of the voice allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module valloc_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [valloc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire [valloc_pkg::ACT_W-1:0]       m_axis_tuser
);

  // A result that waits keeps its contents
  `VA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // One request at a time: input closes right after an accept
  `VA_ASSERT_NXT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Stop-all addresses voice zero with no note or velocity
  `VA_ASSERT_IMP(a_stop_all_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == valloc_pkg::ACT_STOP_ALL), m_axis_tdata == '0)

  // Stop carries no note or velocity
  `VA_ASSERT_IMP(a_stop_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == valloc_pkg::ACT_STOP), m_axis_tdata[valloc_pkg::OUT_DATA_W-1:valloc_pkg::VOICE_W] == '0)

endmodule

bind synth_voice_allocator_unit valloc_checker u_valloc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
